// ===== hw/rtl/paef_pkg.sv =====
// ----------------------------------------------------------------------------
// paef_pkg
// Types and constants shared by the pre-alignment edit filter.
// ----------------------------------------------------------------------------
package paef_pkg;

    localparam int MAX_LEN_DEF   = 256;
    localparam int MAX_EDITS_DEF = 16;

    localparam int BASE_W  = 8;
    localparam int THR_W   = 5;
    localparam int EDITS_W = 5;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

    typedef struct packed {
        logic [BASE_W-1:0] read_base;
        logic [BASE_W-1:0] ref_base;
        logic              last;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [EDITS_W-1:0] edits_used;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic init;
        logic eval;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FILL,
        S_RUN,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/paef_store.sv =====
// ----------------------------------------------------------------------------
// paef_store
// Base store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module paef_store
    import paef_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BASE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BASE_W-1:0] o_rdata
);

    logic [BASE_W-1:0] r_mem [2**AW];
    logic [BASE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/paef_cell.sv =====
// ----------------------------------------------------------------------------
// paef_cell
// One diagonal of the filter: holds a read tap of the window and whether
// the run on its diagonal is still going.
// ----------------------------------------------------------------------------
module paef_cell
    import paef_pkg::*;
#(
    parameter int PW    = 11,
    parameter int EW    = 5,
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [EW-1:0]        i_e,
    input  logic signed [PW-1:0] i_j,
    input  logic signed [PW-1:0] i_n,
    input  logic [BASE_W-1:0]    i_base,
    input  logic [BASE_W-1:0]    i_ref,
    output logic [BASE_W-1:0]    o_base,
    output logic                 o_alive_n
);

    localparam int ABS = (SHIFT < 0) ? -SHIFT : SHIFT;
    localparam logic [EW-1:0] ABS_E = EW'(ABS);
    localparam logic signed [PW-1:0] SHIFT_P = PW'(SHIFT);

    logic [BASE_W-1:0]    r_base;
    logic                 r_alive;
    logic signed [PW-1:0] idx;
    logic                 in_range;

    always_comb begin
        idx       = i_j + SHIFT_P;
        in_range  = (idx >= 0) && (idx < i_n);
        o_alive_n = r_alive && in_range && (r_base == i_ref);
    end

    always_ff @(posedge i_clk) begin
        r_base <= i_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else if (i_ctl.init) begin
            r_alive <= (ABS_E <= i_e);
        end else if (i_ctl.eval) begin
            r_alive <= o_alive_n;
        end
    end

    assign o_base = r_base;

endmodule

// ===== hw/rtl/pre_alignment_edit_filter.sv =====
// ----------------------------------------------------------------------------
// pre_alignment_edit_filter
// Greedy diagonal-run pre-alignment filter over a stored read pair.
//
// Input words carry one read base and one reference base; the word with
// last set closes the pair. Words are taken one per cycle while loading;
// o_stall is high while the filter walks or waits to post its result.
// Bases past MAX_LEN are dropped and the pair is flagged in the result.
// The walk runs in rounds. Each round refills a window of 2*MAX_EDITS+1
// read bases from the registered store, then steps one position a cycle
// down the row of diagonal cells until every run has ended or the read
// ends, then settles the checkpoint in S_NEXT; an exact match skips that.
// One result word follows per pair.
// The result sits in an output register; loading of the next pair goes on
// while it waits, and only a finished walk waits for i_stall to drop.
// Reset empties the pair, drops any pending result and sets the threshold to 2.
// ----------------------------------------------------------------------------
module pre_alignment_edit_filter
    import paef_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_EDITS = MAX_EDITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_in,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int EW = $clog2(MAX_EDITS + 2);
    localparam int PW = $clog2(MAX_LEN + 2 * MAX_EDITS + 4) + 1;
    localparam int NC = 2 * MAX_EDITS + 1;
    localparam int FW = $clog2(NC + 1);
    localparam logic [LW-1:0] FULL = LW'(MAX_LEN);
    localparam logic signed [PW-1:0] M_P = PW'(MAX_EDITS);
    localparam logic [FW-1:0] FILL_LAST = FW'(NC - 1);
    localparam logic [EW-1:0] MAXE_E = EW'(MAX_EDITS);

    t_state               r_state, n_state;
    logic [LW-1:0]        r_cnt, n_cnt;
    logic                 r_ov, n_ov;
    logic signed [PW-1:0] r_c, n_c;
    logic signed [PW-1:0] r_j, n_j;
    logic signed [PW-1:0] r_p, n_p;
    logic signed [PW-1:0] r_run, n_run;
    logic [EW-1:0]        r_edits, n_edits;
    logic [FW-1:0]        r_fill, n_fill;
    logic                 r_exact, n_exact;
    logic                 r_t1, r_t2, n_t1;
    logic                 r_ovalid, n_ovalid;
    t_out                 r_out, n_out;
    logic [THR_W-1:0]     r_thr;

    logic [EW-1:0]        e_lim;
    logic signed [PW-1:0] n_len;
    logic                 accept_in;
    logic                 store_we;
    logic [BASE_W-1:0]    rd_read, rd_ref;
    logic [BASE_W-1:0]    r_ref;
    logic signed [PW-1:0] ref_addr;
    t_cell_ctl            ctl;
    logic [BASE_W-1:0]    taps [NC+1];
    logic [NC-1:0]        alive_n;
    logic                 any_n;
    logic                 last_j;
    logic signed [PW-1:0] cp_inc;
    logic [EW-1:0]        ed_inc;

    always_comb begin
        if (32'(r_thr) > 32'(MAX_EDITS)) begin
            e_lim = MAXE_E;
        end else begin
            e_lim = EW'(r_thr);
        end
    end

    assign n_len     = PW'(r_cnt);
    assign accept_in = i_valid && !o_stall;
    assign store_we  = accept_in && (r_cnt != FULL);
    assign ref_addr  = r_p - M_P;

    paef_store #(.AW(AW)) u_read_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_in.read_base),
        .i_raddr (r_p[AW-1:0]),
        .o_rdata (rd_read)
    );

    paef_store #(.AW(AW)) u_ref_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_in.ref_base),
        .i_raddr (ref_addr[AW-1:0]),
        .o_rdata (rd_ref)
    );

    always_ff @(posedge i_clk) begin
        r_ref <= rd_ref;
    end

    // cell k follows the diagonal shifted by MAX_EDITS-k
    assign taps[0] = rd_read;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        paef_cell #(
            .PW    (PW),
            .EW    (EW),
            .SHIFT (MAX_EDITS - k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_e       (e_lim),
            .i_j       (r_j),
            .i_n       (n_len),
            .i_base    (taps[k]),
            .i_ref     (r_ref),
            .o_base    (taps[k+1]),
            .o_alive_n (alive_n[k])
        );
    end

    assign any_n  = |alive_n;
    assign last_j = (r_j == n_len - PW'(1));
    assign cp_inc = r_c + PW'(1);
    assign ed_inc = r_edits + EW'(1);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ov     = r_ov;
        n_c      = r_c;
        n_j      = r_j;
        n_p      = r_p + PW'(1);
        n_run    = r_run;
        n_edits  = r_edits;
        n_fill   = r_fill;
        n_exact  = r_exact;
        n_t1     = 1'b0;
        n_ovalid = r_ovalid && i_stall;
        n_out    = r_out;
        ctl      = '{init: 1'b0, eval: 1'b0};
        o_stall  = 1'b1;

        case (r_state)
            S_LOAD: begin
                o_stall = 1'b0;
                if (accept_in) begin
                    if (r_cnt != FULL) begin
                        n_cnt = r_cnt + LW'(1);
                    end else begin
                        n_ov = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = S_FILL;
                        n_c     = '0;
                        n_edits = '0;
                        n_exact = 1'b0;
                        n_p     = -M_P;
                        n_fill  = '0;
                    end
                end
            end
            S_FILL: begin
                ctl.init = 1'b1;
                n_fill   = r_fill + FW'(1);
                if (r_fill == FILL_LAST) begin
                    n_t1    = 1'b1;
                    n_state = S_RUN;
                    n_j     = r_c;
                    n_run   = '0;
                end
            end
            S_RUN: begin
                n_t1 = 1'b1;
                if (r_t2) begin
                    ctl.eval = 1'b1;
                    n_j      = r_j + PW'(1);
                    if (any_n) begin
                        n_run = r_run + PW'(1);
                    end
                    if (!any_n || last_j) begin
                        if (r_c == '0 && last_j && alive_n[MAX_EDITS]) begin
                            n_exact = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_c     = r_c + n_run;
                            n_state = S_NEXT;
                        end
                    end
                end
            end
            S_NEXT: begin
                n_state = S_DONE;
                if (r_c < n_len) begin
                    n_edits = ed_inc;
                    n_c     = cp_inc;
                    if ((cp_inc < n_len) && (ed_inc <= e_lim)) begin
                        n_state = S_FILL;
                        n_p     = cp_inc - M_P;
                        n_fill  = '0;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid         = 1'b1;
                    n_out.accepted   = r_exact || (r_edits <= e_lim);
                    n_out.edits_used = EDITS_W'(r_edits);
                    n_out.overflow   = r_ov;
                    n_cnt            = '0;
                    n_ov             = 1'b0;
                    n_state          = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
            r_t1     <= 1'b0;
            r_t2     <= 1'b0;
            r_ovalid <= 1'b0;
            r_thr    <= THR_RESET;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ov     <= n_ov;
            r_t1     <= n_t1;
            r_t2     <= r_t1;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_j     <= n_j;
        r_p     <= n_p;
        r_run   <= n_run;
        r_edits <= n_edits;
        r_fill  <= n_fill;
        r_exact <= n_exact;
        r_out   <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

endmodule

// ===== tb/filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filter_checker
// Watches both channels of the edit filter, computes the expected verdict
// of each read pair from the words accepted and compares it with the result.
// ----------------------------------------------------------------------------
module filter_checker
    import paef_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_EDITS = MAX_EDITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall_in,
    input  t_in              i_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out             i_out,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    logic [BASE_W-1:0] pair_read [MAX_LEN];
    logic [BASE_W-1:0] pair_ref  [MAX_LEN];
    int                pair_len;
    logic              pair_dropped;
    logic [THR_W-1:0]  threshold;
    t_out              verdict_q[$];

    assign o_pending = verdict_q.size();

    function automatic int run_length(int shift, int start, int n);
        int run;
        int qi;
        run = 0;
        for (int j = start; j < n; j++) begin
            qi = j + shift;
            if (qi < 0 || qi >= n) break;
            if (pair_read[qi] != pair_ref[j]) break;
            run++;
        end
        return run;
    endfunction

    function automatic t_out filter_verdict(int n, logic dropped);
        t_out v;
        int   lim;
        int   cp;
        int   edits;
        int   best;
        int   run;
        bit   exact;
        lim = (threshold > MAX_EDITS) ? MAX_EDITS : int'(threshold);
        cp = 0;
        edits = 0;
        exact = 0;
        while (cp < n && edits <= lim) begin
            best = 0;
            run = run_length(0, cp, n);
            if (run == n) begin
                exact = 1;
                break;
            end
            best = run;
            for (int s = 1; s <= lim; s++) begin
                run = run_length(-s, cp, n);
                if (run > best) best = run;
                run = run_length(s, cp, n);
                if (run > best) best = run;
            end
            cp += best;
            if (cp < n) begin
                edits++;
                cp++;
            end
        end
        v.accepted   = exact || edits <= lim;
        v.edits_used = EDITS_W'(edits);
        v.overflow   = dropped;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pair_len     = 0;
            pair_dropped = 0;
            threshold    = THR_RESET;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) threshold = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word %p", i_out);
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== i_out) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result mismatch: expected %p, got %p", want, i_out);
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                if (pair_len < MAX_LEN) begin
                    pair_read[pair_len] = i_in.read_base;
                    pair_ref[pair_len]  = i_in.ref_base;
                    pair_len++;
                end else begin
                    pair_dropped = 1;
                end
                if (i_in.last) begin
                    verdict_q.push_back(filter_verdict(pair_len, pair_dropped));
                    pair_len     = 0;
                    pair_dropped = 0;
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives read pairs of random length and similarity into the edit filter,
// with random gaps and output stalls, across several threshold settings.
// ----------------------------------------------------------------------------
module testbench;
    import paef_pkg::*;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_valid = 0;
    logic             o_stall;
    t_in              i_in = '0;
    logic             o_valid;
    logic             i_stall = 0;
    t_out             o_out;
    logic             i_cfg_we = 0;
    logic [THR_W-1:0] i_cfg_data = '0;
    int               fail_count;
    int               pending;
    bit               calm = 0;

    logic [BASE_W-1:0] rd [300];
    logic [BASE_W-1:0] rf [300];

    always #4 i_clk = ~i_clk;

    pre_alignment_edit_filter uut (.*);

    filter_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_in(i_in), .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    task automatic send_word(logic [7:0] a, logic [7:0] b, logic lst);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in.read_base <= a;
        i_in.ref_base  <= b;
        i_in.last      <= lst;
        i_valid        <= 1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // similar pair: ref copy of the read with a few edits
    task automatic send_pair(int len, int nedits, bit noise);
        int p;
        for (int k = 0; k < len; k++) begin
            rd[k] = noise ? 8'($urandom) : 8'($urandom_range(0, 3));
            rf[k] = rd[k];
        end
        for (int k = 0; k < nedits; k++) begin
            p = $urandom_range(0, len - 1);
            case ($urandom_range(0, 2))
                0: rf[p] = 8'($urandom);
                1: begin
                    for (int m = len - 1; m > p; m--) rf[m] = rf[m-1];
                end
                default: begin
                    for (int m = p; m < len - 1; m++) rf[m] = rf[m+1];
                end
            endcase
        end
        for (int k = 0; k < len; k++) send_word(rd[k], rf[k], k == len - 1);
        i_valid <= 0;
    endtask

    task automatic set_threshold(logic [THR_W-1:0] t);
        while (pending != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
        i_cfg_data <= t;
        i_cfg_we   <= 1;
        @(negedge i_clk);
        i_cfg_we   <= 0;
    endtask

    initial begin
        logic [THR_W-1:0] thr [7];
        int len;
        thr = '{THR_W'(0), THR_W'(1), THR_W'(16), THR_W'(31), THR_W'(4), THR_W'(2),
                THR_W'(8)};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        send_word(8'h00, 8'h00, 1);
        send_word(8'hFF, 8'hFF, 0);
        send_word(8'hFF, 8'h00, 1);
        send_pair(8, 0, 1);
        send_pair(10, 3, 0);
        send_pair(2, 1, 1);
        for (int k = 0; k < 258; k++) send_word(8'hAA, 8'h55, k == 257);
        send_pair(6, 2, 0);
        foreach (thr[t]) begin
            set_threshold(thr[t]);
            if (t == 6) calm = 1;
            for (int p = 0; p < 8; p++) begin
                len = ($urandom_range(0, 20) == 0) ? $urandom_range(100, 260)
                                                   : $urandom_range(1, 12);
                send_pair(len, $urandom_range(0, 4), $urandom_range(0, 4) == 0);
            end
        end
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/paef_pkg.sv
hw/rtl/paef_store.sv
hw/rtl/paef_cell.sv
hw/rtl/pre_alignment_edit_filter.sv
tb/filter_checker.sv
tb/testbench.sv
